>>> rtl/core/cmbm_pkg.sv
// Shared types and constants for the cartridge mapper register write block.
package cmbm_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int BANK_W   = 5;
    localparam int COUNT_W  = 9;
    localparam int KIND_W   = 2;
    localparam int SHIFT_CNT_W = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SERIAL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISCRETE = 2'd2;

    localparam logic CFG_MAPPER_KIND    = 1'b0;
    localparam logic CFG_CHR_BANK_COUNT = 1'b1;

    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    localparam logic [BANK_W-1:0]      SHIFT_EMPTY   = 5'h10;
    localparam logic [BANK_W-1:0]      CONTROL_RESET = 5'h0C;
    localparam logic [SHIFT_CNT_W-1:0] SHIFT_LAST    = 3'd5;

    typedef struct packed {
        logic [BANK_W-1:0] control;
        logic [BANK_W-1:0] chr_low;
        logic [BANK_W-1:0] chr_high;
        logic [BANK_W-1:0] prg;
        logic              mirror;
        logic [DATA_W-1:0] discrete;
    } mapper_regs_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] remainder;
    } mod_rsp_t;

endpackage

>>> rtl/core/cmbm_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
module cmbm_mod_unit
    import cmbm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mod_req_t req,
    output mod_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SHIFT_CNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0]      dvd_reg, dvd_next;
    logic [COUNT_W-1:0]     divisor_reg, divisor_next;
    logic [COUNT_W-1:0]     trial;

    assign trial = {rem_reg[COUNT_W-2:0], dvd_reg[DATA_W-1]};

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        divisor_next = divisor_reg;
        if (req.start && !busy_reg) begin
            busy_next    = 1'b1;
            count_next   = '0;
            rem_next     = '0;
            dvd_next     = req.dividend;
            divisor_next = req.divisor;
        end else if (busy_reg) begin
            rem_next   = (trial >= divisor_reg) ? trial - divisor_reg : trial;
            dvd_next   = {dvd_reg[DATA_W-2:0], 1'b0};
            count_next = count_reg + 1'b1;
            if (count_reg == SHIFT_CNT_W'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[DATA_W-1:0];

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && !busy_reg) |=> busy_reg)
        else $error("mod unit did not start");

    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && divisor_reg != '0) |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("mod unit count did not advance");

endmodule

>>> rtl/core/cmbm_map_regs.sv
// Mapper register file with serial shift loader and discrete bank register.
module cmbm_map_regs
    import cmbm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] data,
    input  logic [KIND_W-1:0] kind,
    input  logic              count_zero,
    input  logic [DATA_W-1:0] mod_rem,
    output mapper_regs_t      regs_next,
    output logic              load_done
);

    mapper_regs_t           regs_reg;
    logic [BANK_W-1:0]      shift_reg, shift_next, shifted;
    logic [SHIFT_CNT_W-1:0] scount_reg, scount_next, scount_inc;

    assign shifted    = {data[0], shift_reg[BANK_W-1:1]};
    assign scount_inc = scount_reg + 1'b1;

    always_comb begin
        regs_next   = regs_reg;
        shift_next  = shift_reg;
        scount_next = scount_reg;
        load_done   = 1'b0;
        if (addr[ADDR_W-1]) begin
            case (kind)
                KIND_SERIAL: begin
                    if (data[DATA_W-1]) begin
                        shift_next        = SHIFT_EMPTY;
                        scount_next       = '0;
                        regs_next.control = regs_reg.control | CONTROL_RESET;
                    end else if (scount_inc == SHIFT_LAST) begin
                        shift_next  = SHIFT_EMPTY;
                        scount_next = '0;
                        load_done   = 1'b1;
                        case (addr[14:13])
                            TGT_CONTROL: begin
                                regs_next.control = shifted;
                                regs_next.mirror  = &shifted[1:0];
                            end
                            TGT_CHR_LOW:  regs_next.chr_low  = shifted;
                            TGT_CHR_HIGH: regs_next.chr_high = shifted;
                            default:      regs_next.prg      = shifted;
                        endcase
                    end else begin
                        shift_next  = shifted;
                        scount_next = scount_inc;
                    end
                end
                KIND_DISCRETE: begin
                    regs_next.discrete = count_zero ? '0 : mod_rem;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.control  <= CONTROL_RESET;
            regs_reg.chr_low  <= '0;
            regs_reg.chr_high <= '0;
            regs_reg.prg      <= '0;
            regs_reg.mirror   <= 1'b0;
            regs_reg.discrete <= '0;
            shift_reg         <= SHIFT_EMPTY;
            scount_reg        <= '0;
        end else if (commit) begin
            regs_reg   <= regs_next;
            shift_reg  <= shift_next;
            scount_reg <= scount_next;
        end
    end

endmodule

>>> rtl/core/cartridge_mapper_register_write.sv
// Top level of the cartridge mapper register write block.
//
// Slave stream s_*: one word per CPU write, address and data byte.
// Master stream m_*: one word per accepted write, the mapper registers as
// they stand after that write, plus a flag for a completed five-bit load.
// Config port cfg_*: index 0 mapper kind, index 1 character bank count;
// write only while no word is in flight.
// An accepted write passes to the put state, where it is registered into the
// output register; a discrete mapper write at or above 0x8000 with a non-zero
// bank count first waits in the divide state for the remainder unit, which
// retires one data bit per cycle. A new write is taken only after the last
// one has left the put state; a stalled receiver delays this.
// One write is worked on at a time; s_tready is high whenever the
// sequencer is idle, also while a result waits in the output register.
// A stalled receiver holds m_tdata; a finished write waits in the put
// state until the output register frees, and s_tready stays low until
// then. Reset clears mapper kind and bank count to 0, the control
// register to 0x0C, the shift register to empty and all banks to 0.
module cartridge_mapper_register_write
    import cmbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // write_address [15:0], write_data [23:16]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // control_value [4:0], chr_bank_low [9:5], chr_bank_high [14:10],
    // prg_bank_value [19:15], horizontal_mirroring [20],
    // discrete_chr_bank [28:21], load_complete [29], zero [31:30]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [COUNT_W-1:0]   cfg_wdata
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUT} state_t;

    state_t              state_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [COUNT_W-1:0]  bank_count_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [M_TDATA_W-1:0] out_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   rem_reg;

    mod_req_t     mreq;
    mod_rsp_t     mrsp;
    mapper_regs_t regs_next;
    logic         load_done;
    logic         commit;
    logic         s_accept;
    logic         need_div;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign need_div = s_tdata[ADDR_W-1] && (kind_reg == KIND_DISCRETE)
                      && (bank_count_reg != '0);
    assign commit   = (state_reg == S_PUT) && (!out_valid_reg || m_tready);

    assign mreq.start    = s_accept && need_div;
    assign mreq.dividend = s_tdata[ADDR_W +: DATA_W];
    assign mreq.divisor  = bank_count_reg;

    cmbm_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    cmbm_map_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .commit     (commit),
        .addr       (addr_reg),
        .data       (data_reg),
        .kind       (kind_reg),
        .count_zero (bank_count_reg == '0),
        .mod_rem    (rem_reg),
        .regs_next  (regs_next),
        .load_done  (load_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            kind_reg       <= KIND_NONE;
            bank_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MAPPER_KIND:    kind_reg       <= cfg_wdata[KIND_W-1:0];
                    CFG_CHR_BANK_COUNT: bank_count_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= need_div ? S_DIV : S_PUT;
                    end
                end
                S_DIV: begin
                    if (mrsp.done) begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (commit) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
        if (s_accept) begin
            addr_reg <= s_tdata[ADDR_W-1:0];
            data_reg <= s_tdata[ADDR_W +: DATA_W];
        end
        if (mrsp.done) begin
            rem_reg <= mrsp.remainder;
        end
        if (commit) begin
            out_reg <= {2'b00, load_done, regs_next.discrete, regs_next.mirror,
                        regs_next.prg, regs_next.chr_high, regs_next.chr_low,
                        regs_next.control};
        end
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the cartridge mapper register write block.
module testbench;
    import cmbm_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] CART_BASE   = 16'h8000;

    typedef struct packed {
        logic              load_done;
        logic [DATA_W-1:0] discrete;
        logic              mirror;
        logic [BANK_W-1:0] prg;
        logic [BANK_W-1:0] chr_high;
        logic [BANK_W-1:0] chr_low;
        logic [BANK_W-1:0] control;
    } mapper_result_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        bit                drain_first;
    } cpu_write_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = CFG_MAPPER_KIND;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    cpu_write_t     cpu_writes[$];
    mapper_result_t pending_results[$];
    cpu_write_t     on_bus;
    int             mismatch_count = 0;
    bit             drain_next = 1'b0;
    int             send_wait = 0;
    int             recv_wait = 0;
    bit             send_burst = 1'b0;
    bit             recv_burst = 1'b0;
    bit             word_taken;

    // mirror of the block's registers and configuration
    logic [KIND_W-1:0]      model_kind = KIND_NONE;
    logic [COUNT_W-1:0]     model_count = '0;
    logic [BANK_W-1:0]      shift_bits = SHIFT_EMPTY;
    logic [SHIFT_CNT_W-1:0] shift_count = '0;
    logic [BANK_W-1:0]      control_reg = CONTROL_RESET;
    logic [BANK_W-1:0]      chr_low_reg = '0;
    logic [BANK_W-1:0]      chr_high_reg = '0;
    logic [BANK_W-1:0]      prg_reg = '0;
    logic                   mirror_flag = 1'b0;
    logic [DATA_W-1:0]      discrete_bank_reg = '0;

    cartridge_mapper_register_write DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic mapper_result_t apply_cpu_write(input logic [ADDR_W-1:0] addr,
                                                       input logic [DATA_W-1:0] data);
        mapper_result_t res;
        res.load_done = 1'b0;
        if (addr >= CART_BASE) begin
            if (model_kind == KIND_SERIAL) begin
                if (data[7]) begin
                    shift_bits  = SHIFT_EMPTY;
                    shift_count = '0;
                    control_reg = control_reg | CONTROL_RESET;
                end else begin
                    shift_bits  = {data[0], shift_bits[BANK_W-1:1]};
                    shift_count = shift_count + 1'b1;
                    if (shift_count == SHIFT_LAST) begin
                        case (addr[14:13])
                            TGT_CONTROL: begin
                                control_reg = shift_bits;
                                mirror_flag = (shift_bits[1:0] == 2'b11);
                            end
                            TGT_CHR_LOW:  chr_low_reg = shift_bits;
                            TGT_CHR_HIGH: chr_high_reg = shift_bits;
                            default:      prg_reg = shift_bits;
                        endcase
                        shift_bits    = SHIFT_EMPTY;
                        shift_count   = '0;
                        res.load_done = 1'b1;
                    end
                end
            end else if (model_kind == KIND_DISCRETE) begin
                if (model_count == '0)
                    discrete_bank_reg = '0;
                else
                    discrete_bank_reg = DATA_W'({1'b0, data} % model_count);
            end
        end
        res.control  = control_reg;
        res.chr_low  = chr_low_reg;
        res.chr_high = chr_high_reg;
        res.prg      = prg_reg;
        res.mirror   = mirror_flag;
        res.discrete = discrete_bank_reg;
        return res;
    endfunction

    function automatic void report_field(input string field, input int unsigned want,
                                         input int unsigned seen);
        if (want != seen) begin
            if (mismatch_count < 10)
                $display("mismatch in %s: expected %0d, got %0d", field, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            send_wait = 0;
        end else begin
            word_taken = s_tvalid && s_tready;
            if (word_taken) begin
                pending_results.push_back(apply_cpu_write(on_bus.addr, on_bus.data));
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(0, 5);
            end
            if (s_tvalid && !word_taken) begin
                // hold the word until taken
            end else if (send_wait > 0) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (cpu_writes.size() > 0 &&
                         !(cpu_writes[0].drain_first && pending_results.size() > 0)) begin
                on_bus = cpu_writes.pop_front();
                s_tdata  <= {on_bus.data, on_bus.addr};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        mapper_result_t want;
        mapper_result_t seen;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[$bits(mapper_result_t)-1:0];
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result word %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    report_field("control_value", want.control, seen.control);
                    report_field("chr_bank_low", want.chr_low, seen.chr_low);
                    report_field("chr_bank_high", want.chr_high, seen.chr_high);
                    report_field("prg_bank_value", want.prg, seen.prg);
                    report_field("horizontal_mirroring", want.mirror, seen.mirror);
                    report_field("discrete_chr_bank", want.discrete, seen.discrete);
                    report_field("load_complete", want.load_done, seen.load_done);
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 5);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic idx, input logic [COUNT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MAPPER_KIND)
            model_kind = val[KIND_W-1:0];
        else
            model_count = val;
    endtask

    task automatic set_mapper(input logic [KIND_W-1:0] kind, input logic [COUNT_W-1:0] cnt);
        write_register(CFG_MAPPER_KIND, COUNT_W'(kind));
        write_register(CFG_CHR_BANK_COUNT, cnt);
        drain_next = 1'b1;
    endtask

    // sample away from the rising edge so that the driver has settled
    task automatic wait_idle();
        while (cpu_writes.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic queue_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        cpu_write_t w;
        w.addr        = addr;
        w.data        = data;
        w.drain_first = drain_next || ($urandom_range(0, 149) == 0);
        drain_next    = 1'b0;
        cpu_writes.push_back(w);
    endtask

    // five bit writes, LSB first; the last address picks the register
    task automatic queue_serial_load(input logic [1:0] target, input logic [BANK_W-1:0] value,
                                     input bit noisy);
        int i;
        for (i = 0; i < BANK_W; i++) begin
            if (noisy && $urandom_range(0, 19) == 0)
                queue_write(ADDR_W'($urandom_range(0, 16'h7FFF)), DATA_W'($urandom));
            if (noisy && $urandom_range(0, 39) == 0)
                queue_write({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
            queue_write({1'b1, target, 13'($urandom)},
                        {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic random_phase(input int n);
        int               done_items;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        done_items = 0;
        while (done_items < n) begin
            if (model_kind == KIND_SERIAL && $urandom_range(0, 9) < 7) begin
                queue_serial_load(2'($urandom), BANK_W'($urandom), 1'b1);
                done_items += BANK_W;
            end else begin
                addr = ADDR_W'($urandom);
                data = DATA_W'($urandom);
                if (model_kind == KIND_DISCRETE && $urandom_range(0, 4) != 0)
                    addr[15] = 1'b1;
                queue_write(addr, data);
                if (addr[15] || (model_kind != KIND_SERIAL && model_kind != KIND_DISCRETE))
                    done_items++;
            end
        end
    endtask

    initial begin
        logic [KIND_W-1:0]  phase_kind[12];
        logic [COUNT_W-1:0] phase_count[12];
        int p;
        phase_kind  = '{KIND_SERIAL, KIND_DISCRETE, KIND_SERIAL, KIND_DISCRETE, KIND_NONE,
                        KIND_SERIAL, KIND_DISCRETE, KIND_UNUSED, KIND_DISCRETE, KIND_SERIAL,
                        KIND_DISCRETE, KIND_SERIAL};
        phase_count = '{9'd5, 9'd0, 9'd256, 9'd1, 9'd3, 9'd0, 9'd511, 9'd7, 9'd8, 9'd511,
                        9'($urandom_range(2, 255)), 9'd256};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // registers as reset: nothing changes
        queue_write(16'hFFFF, 8'hFF);
        queue_write(16'h8000, 8'h00);
        wait_idle();

        set_mapper(KIND_SERIAL, 9'd0);
        queue_write(16'h7FFF, 8'h01);
        queue_write(16'h8000, 8'h80);
        queue_serial_load(TGT_CONTROL, 5'h03, 1'b0);
        queue_write(16'h9FFF, 8'h7F);
        queue_write(16'h8001, 8'h7E);
        queue_write(16'hA000, 8'hFF);
        queue_serial_load(TGT_PRG, 5'h1F, 1'b0);
        wait_idle();

        set_mapper(KIND_DISCRETE, 9'd0);
        queue_write(16'hFFFF, 8'hFF);
        wait_idle();
        set_mapper(KIND_DISCRETE, 9'd256);
        queue_write(16'h8000, 8'hFF);
        wait_idle();
        set_mapper(KIND_DISCRETE, 9'd3);
        queue_write(16'hC000, 8'hFF);
        queue_write(16'h7FFF, 8'h10);
        wait_idle();
        set_mapper(KIND_DISCRETE, 9'd511);
        queue_write(16'hC000, 8'hFE);
        wait_idle();
        set_mapper(KIND_UNUSED, 9'd1);
        queue_write(16'hE000, 8'h00);
        wait_idle();

        for (p = 0; p < 12; p++) begin
            set_mapper(phase_kind[p], phase_count[p]);
            random_phase(phase_kind[p] == KIND_SERIAL ? 210 :
                         phase_kind[p] == KIND_DISCRETE ? 110 : 30);
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("cartridge_mapper_register_write verification clean");
        end else begin
            $display("cartridge_mapper_register_write verification failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("cartridge_mapper_register_write verification failed");
        $finish;
    end

endmodule
